// ===== hdl/ubx_pkg.sv =====
// ---------------------------------------------------------------------------
// ubx_pkg: shared types and constants for the UBX frame builder
// Frame constants, item codes and the job descriptor that travels from the
// front end to the byte serializer.
// ---------------------------------------------------------------------------
`default_nettype none

package ubx_pkg;

   // Frame preamble
   localparam logic [7:0] SYNC1 = 8'hB5;
   localparam logic [7:0] SYNC2 = 8'h62;

   // Input item kinds (req_tuser)
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   // Byte positions in a job; header jobs start at POS_SYNC1, payload and
   // stray-payload jobs start at POS_DATA3
   localparam int POS_W = 3;
   localparam logic [POS_W-1:0] POS_SYNC1 = 3'd0;
   localparam logic [POS_W-1:0] POS_SYNC2 = 3'd1;
   localparam logic [POS_W-1:0] POS_DATA0 = 3'd2;
   localparam logic [POS_W-1:0] POS_DATA1 = 3'd3;
   localparam logic [POS_W-1:0] POS_DATA2 = 3'd4;
   localparam logic [POS_W-1:0] POS_DATA3 = 3'd5;
   localparam logic [POS_W-1:0] POS_CK_A  = 3'd6;
   localparam logic [POS_W-1:0] POS_CK_B  = 3'd7;

   // Job queue depth
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // One classified item: which bytes to send and with which flags
   typedef struct packed {
      logic            hdr;     // full header (else a single data byte)
      logic [3:0][7:0] data;    // class, id, len lo, len hi; data[3] alone otherwise
      logic            has_ck;  // append CK_A and CK_B
      logic [7:0]      ck_a;
      logic [7:0]      ck_b;
      logic            err;
   } ubx_job_type;

endpackage

`default_nettype wire

// ===== hdl/ubx_frame_builder_top.sv =====
// ---------------------------------------------------------------------------
// ubx_frame_builder_top: UBX frame builder with Fletcher-8 checksum
// Turns start and payload items into the transmit byte stream of a frame.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one item per handshake. req_tuser = 0 starts a frame with
//   class, id and length; req_tuser = 1 carries one payload byte.
//   rsp channel: one frame byte per handshake. rsp_tlast marks the last byte
//   caused by an input item, rsp_tuser flags CK_B and protocol errors.
//   A start yields 6 bytes (8 when the length is zero), a payload item 1 byte
//   (3 with the closing checksum), a stray payload item one error byte.
// Path: accepted items are queued, then each byte is registered for output.
// Throughput: the serializer sends one byte per cycle while rsp_tready is
//   high; payload items flow at one per cycle, header and checksum bytes
//   too, and the 4-entry job queue absorbs bursts before req_tready drops.
// Reset: clears the frame state, the job queue and the output stage; no
//   frame is open afterwards.
// Stall: when rsp_tready is low the output byte holds, the queue fills and
//   req_tready falls once all 4 queue entries are taken.
// ---------------------------------------------------------------------------
`default_nettype none

module ubx_frame_builder_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // msg_class[7:0], msg_id[15:8],
                                    // payload_len[31:16], payload_byte[39:32]
   input  wire  [0:0]  req_tuser,   // command[0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // tx_byte[7:0]
   output logic        rsp_tlast,   // last_in_run
   output logic [1:0]  rsp_tuser    // frame_done[0], error[1]
);
   import ubx_pkg::*;

   ubx_job_type new_job;
   ubx_job_type head_job;
   logic        q_full;
   logic        head_valid;
   logic        pop;
   logic        accept;
   logic        frame_done;
   logic        error;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   // Classify items and keep frame state
   ubx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept),
      .item_cmd   (req_tuser[0]),
      .item_class (req_tdata[7:0]),
      .item_id    (req_tdata[15:8]),
      .item_len   (req_tdata[31:16]),
      .item_byte  (req_tdata[39:32]),
      .job        (new_job)
   );

   // Decouple classification from serialization
   ubx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_job   (new_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Serialize jobs into frame bytes
   ubx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_last   (rsp_tlast),
      .out_done   (frame_done),
      .out_err    (error)
   );

   assign rsp_tuser = {error, frame_done};

endmodule

`default_nettype wire

// ===== hdl/ubx_front.sv =====
// ---------------------------------------------------------------------------
// ubx_front: item classifier and frame state
// Accepts start and payload items, tracks the open frame, runs the Fletcher
// sums and issues one job per item to the job queue.
// ---------------------------------------------------------------------------
`default_nettype none

module ubx_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 item_valid,
   input  wire                 item_cmd,
   input  wire  [7:0]          item_class,
   input  wire  [7:0]          item_id,
   input  wire  [15:0]         item_len,
   input  wire  [7:0]          item_byte,
   output ubx_pkg::ubx_job_type job
);
   import ubx_pkg::*;

   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic        frame_open_ff, frame_open_in;

   logic [7:0]  len_lo, len_hi;
   logic [7:0]  hdr_a, hdr_b;
   logic [7:0]  pay_a, pay_b;
   logic [15:0] left_dec;

   assign len_lo   = item_len[7:0];
   assign len_hi   = item_len[15:8];
   assign left_dec = bytes_left_ff - 16'd1;

   // Header sums in closed form: A = c+i+l+h, B = 4c+3i+2l+h (mod 256)
   assign hdr_a = item_class + item_id + len_lo + len_hi;
   assign hdr_b = {item_class[5:0], 2'b00} + item_id + {item_id[6:0], 1'b0}
                + {len_lo[6:0], 1'b0} + len_hi;

   // Running sums for one payload byte
   assign pay_a = sum_a_ff + item_byte;
   assign pay_b = sum_b_ff + pay_a;

   // Classify the item and compute next frame state
   always_comb begin
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      bytes_left_in = bytes_left_ff;
      frame_open_in = frame_open_ff;
      job           = '0;
      if (item_cmd == CMD_START) begin
         job.hdr       = 1'b1;
         job.data      = {len_hi, len_lo, item_id, item_class};
         job.has_ck    = (item_len == 16'd0);
         job.ck_a      = hdr_a;
         job.ck_b      = hdr_b;
         job.err       = frame_open_ff;
         sum_a_in      = hdr_a;
         sum_b_in      = hdr_b;
         bytes_left_in = item_len;
         frame_open_in = (item_len != 16'd0);
      end else if (!frame_open_ff || bytes_left_ff == 16'd0) begin
         // Stray payload: single zero byte flagged as error, state kept
         job.err = 1'b1;
      end else begin
         job.data[3]   = item_byte;
         job.has_ck    = (left_dec == 16'd0);
         job.ck_a      = pay_a;
         job.ck_b      = pay_b;
         sum_a_in      = pay_a;
         sum_b_in      = pay_b;
         bytes_left_in = left_dec;
         frame_open_in = (left_dec != 16'd0);
      end
   end

   // Commit state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
         bytes_left_ff <= '0;
         frame_open_ff <= 1'b0;
      end else if (item_valid) begin
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         bytes_left_ff <= bytes_left_in;
         frame_open_ff <= frame_open_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ubx_queue.sv =====
// ---------------------------------------------------------------------------
// ubx_queue: job queue between front end and serializer
// Small first-in first-out register file; head is visible without a pop.
// ---------------------------------------------------------------------------
`default_nettype none

module ubx_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  ubx_pkg::ubx_job_type push_job,
   output logic                 full,
   input  wire                  pop,
   output logic                 head_valid,
   output ubx_pkg::ubx_job_type head_job
);
   import ubx_pkg::*;

   ubx_job_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]     count_ff;
   logic                  do_pop;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ubx_back.sv =====
// ---------------------------------------------------------------------------
// ubx_back: byte serializer
// Walks the head job byte by byte into a registered output stage and pops
// the job with its last byte.
// ---------------------------------------------------------------------------
`default_nettype none

module ubx_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  head_valid,
   input  ubx_pkg::ubx_job_type head_job,
   output logic                 pop,
   output logic                 out_valid,
   input  wire                  out_ready,
   output logic [7:0]           out_byte,
   output logic                 out_last,
   output logic                 out_done,
   output logic                 out_err
);
   import ubx_pkg::*;

   logic             busy_ff, busy_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             done_ff, done_in;
   logic             err_ff, err_in;

   logic [POS_W-1:0] cur_pos;
   logic [POS_W-1:0] end_pos;
   logic             at_end;
   logic             load;

   // Current byte position within the head job
   assign cur_pos = busy_ff ? pos_ff : (head_job.hdr ? POS_SYNC1 : POS_DATA3);
   assign end_pos = head_job.has_ck ? POS_CK_B : POS_DATA3;
   assign at_end  = (cur_pos == end_pos);
   assign load    = head_valid && (!valid_ff || out_ready);
   assign pop     = load && at_end;

   // Select the byte and advance the position
   always_comb begin
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff && !out_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      err_in   = err_ff;
      if (load) begin
         valid_in = 1'b1;
         last_in  = at_end;
         done_in  = (cur_pos == POS_CK_B);
         err_in   = head_job.err;
         busy_in  = !at_end;
         pos_in   = cur_pos + 1'b1;
         case (cur_pos)
            POS_SYNC1: byte_in = SYNC1;
            POS_SYNC2: byte_in = SYNC2;
            POS_DATA0: byte_in = head_job.data[0];
            POS_DATA1: byte_in = head_job.data[1];
            POS_DATA2: byte_in = head_job.data[2];
            POS_DATA3: byte_in = head_job.data[3];
            POS_CK_A:  byte_in = head_job.ck_a;
            POS_CK_B:  byte_in = head_job.ck_b;
            default:   byte_in = 8'h00;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      done_ff <= done_in;
      err_ff  <= err_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_done  = done_ff;
   assign out_err   = err_ff;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the UBX frame builder
// Feeds start and payload items, predicts every transmitted frame byte with
// its Fletcher-8 checksum, last and error flags, and checks the byte stream
// with random stalls on both sides and a long back-pressure stretch.
// ---------------------------------------------------------------------------

module tb_top;

   import ubx_pkg::*;

   // One predicted output byte with its side-band flags
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
      logic       done;
      logic       err;
   } frame_byte_type;

   // Frame predictor and the queue of bytes still owed by the block
   class frame_byte_board;
      frame_byte_type pending[$];
      logic [7:0]  sum_a = '0;
      logic [7:0]  sum_b = '0;
      logic [15:0] bytes_due = '0;
      logic        in_frame = 1'b0;
      int          mismatches = 0;
      int          bytes_checked = 0;
      int          frames_closed = 0;
      int          error_bytes = 0;

      // Queue one expected byte
      function void push_byte(logic [7:0] b, logic done, logic err);
         frame_byte_type e;
         e.tx_byte = b;
         e.last    = 1'b0;
         e.done    = done;
         e.err     = err;
         pending.push_back(e);
      endfunction

      // Advance both running sums
      function void fold(logic [7:0] b);
         sum_a = sum_a + b;
         sum_b = sum_b + sum_a;
      endfunction

      // Append CK_A and CK_B and close the frame
      function void close_frame(logic err);
         push_byte(sum_a, 1'b0, err);
         push_byte(sum_b, 1'b1, err);
         in_frame  = 1'b0;
         bytes_due = '0;
      endfunction

      // Predict the bytes caused by one accepted input item
      function void take_item(logic cmd, logic [7:0] cls, logic [7:0] mid,
                              logic [15:0] len, logic [7:0] pb);
         logic err;
         if (cmd == CMD_START) begin
            // a start while a frame is open abandons that frame
            err   = in_frame;
            sum_a = '0;
            sum_b = '0;
            fold(cls);
            fold(mid);
            fold(len[7:0]);
            fold(len[15:8]);
            push_byte(SYNC1, 1'b0, err);
            push_byte(SYNC2, 1'b0, err);
            push_byte(cls, 1'b0, err);
            push_byte(mid, 1'b0, err);
            push_byte(len[7:0], 1'b0, err);
            push_byte(len[15:8], 1'b0, err);
            bytes_due = len;
            in_frame  = 1'b1;
            if (len == 16'd0)
               close_frame(err);
         end else if (!in_frame || bytes_due == 16'd0) begin
            // stray payload: dropped, one error byte reported
            push_byte(8'h00, 1'b0, 1'b1);
         end else begin
            fold(pb);
            push_byte(pb, 1'b0, 1'b0);
            bytes_due = bytes_due - 16'd1;
            if (bytes_due == 16'd0)
               close_frame(1'b0);
         end
         pending[pending.size()-1].last = 1'b1;
      endfunction

      // Print one mismatch line and count it
      task report_mismatch(string msg);
         $display("tb_top: mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      // Compare one accepted output byte with the oldest expectation
      task check_byte(logic [7:0] data, logic last, logic [1:0] user);
         frame_byte_type e;
         bytes_checked++;
         if (user[0] === 1'b1)
            frames_closed++;
         if (user[1] === 1'b1)
            error_bytes++;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", data));
         end else begin
            e = pending.pop_front();
            if (data !== e.tx_byte)
               report_mismatch($sformatf("tx_byte %02h, want %02h", data, e.tx_byte));
            if (last !== e.last)
               report_mismatch($sformatf("last_in_run %b, want %b", last, e.last));
            if (user[0] !== e.done)
               report_mismatch($sformatf("frame_done %b, want %b", user[0], e.done));
            if (user[1] !== e.err)
               report_mismatch($sformatf("error %b, want %b", user[1], e.err));
         end
      endtask
   endclass

   // Cycles with no handshake on either side before the run is abandoned;
   // the longest legal quiet stretch is the receiver hold-off
   localparam int IDLE_LIMIT = 3000;
   localparam int NUM_ITEMS  = 320;
   localparam int HOLD_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   frame_byte_board board = new;
   int items_sent = 0;
   int idle_cycles = 0;
   bit held_off = 1'b0;

   ubx_frame_builder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one item, with an occasional gap, and hold it until accepted
   task automatic send_item(input logic cmd, input logic [7:0] cls,
                            input logic [7:0] mid, input logic [15:0] len,
                            input logic [7:0] pb);
      int  gap;
      bit  quiet;
      logic ok;
      quiet = (items_sent >= 230 && items_sent < 290);
      gap = (quiet || $urandom_range(99) >= 14) ? 0 : 1;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {pb, len, mid, cls};
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (ok !== 1'b1);
      board.take_item(cmd, cls, mid, len, pb);
      items_sent++;
   endtask

   // Hold the sender until every predicted byte has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0)
         @(posedge clock);
   endtask

   // Receiver: random stalls, one long hold-off, a stretch with no stalls
   initial begin
      bit quiet;
      forever begin
         @(posedge clock);
         if (!reset && !held_off && board.bytes_checked >= 120) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         quiet = (board.bytes_checked >= 400 && board.bytes_checked < 520);
         rsp_tready <= quiet || ($urandom_range(99) >= 14);
      end
   end

   // Check output bytes and watch for a stalled run, sampled mid-cycle
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_byte(rsp_tdata, rsp_tlast, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: no progress for %0d cycles, %0d bytes outstanding",
                     IDLE_LIMIT, board.pending.size());
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      int          pick;
      int          n;
      logic [15:0] len;
      bit          drained;
      drained = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: stray payloads, empty frames, cut-off frames, extremes
      send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hFF);
      send_item(CMD_PAYLOAD, 8'hFF, 8'hFF, 16'hFFFF, 8'h00);
      send_item(CMD_START, 8'hFF, 8'hFF, 16'h0000, 8'h00);
      send_item(CMD_START, 8'h00, 8'h00, 16'h0000, 8'hFF);
      send_item(CMD_START, 8'h06, 8'h01, 16'h0001, 8'h00);
      send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hFF);
      send_item(CMD_START, 8'hA5, 8'h5A, 16'hFFFF, 8'h00);
      send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00);
      send_item(CMD_START, 8'h01, 8'h02, 16'h0003, 8'h00);
      send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h80);
      send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h7F);
      send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h01);
      send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h33);
      send_item(CMD_START, 8'h0A, 8'h04, 16'h8000, 8'h00);
      send_item(CMD_START, 8'h0B, 8'h09, 16'h0100, 8'h00);
      send_item(CMD_START, 8'h01, 8'h07, 16'h0002, 8'h00);
      send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hAA);
      send_item(CMD_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h55);
      wait_drained();

      // Random: mostly whole frames, some cut-off frames and stray payload
      while (items_sent < NUM_ITEMS) begin
         if (items_sent >= 200 && !drained) begin
            drained = 1'b1;
            wait_drained();
         end
         pick = $urandom_range(99);
         if (pick < 75) begin
            len = ($urandom_range(9) == 0) ? 16'($urandom_range(40, 11))
                                           : 16'($urandom_range(10, 0));
            send_item(CMD_START, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      len, 8'($urandom_range(255)));
            repeat (len)
               send_item(CMD_PAYLOAD, 8'($urandom_range(255)),
                         8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
                         8'($urandom_range(255)));
         end else if (pick < 87) begin
            // frame left open, to be cut off by the next start
            len = 16'($urandom_range(16'hFFFF));
            send_item(CMD_START, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      len, 8'($urandom_range(255)));
            n = $urandom_range(2);
            repeat (n)
               send_item(CMD_PAYLOAD, 8'($urandom_range(255)),
                         8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
                         8'($urandom_range(255)));
         end else begin
            send_item(CMD_PAYLOAD, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
         end
      end

      // Let the last bytes out, then keep watching for any extra bytes
      wait_drained();
      repeat (8) @(posedge clock);

      $display("summary: %0d items sent, %0d bytes checked, %0d frames closed",
               items_sent, board.bytes_checked, board.frames_closed);
      $display("summary: %0d error bytes, %0d mismatches, receiver hold-off %s",
               board.error_bytes, board.mismatches, held_off ? "done" : "missed");
      if (board.mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
